>>> rtl/lfsu_pkg.sv
// Shared types, constants and helpers for the latent-factor SGD update block.
package lfsu_pkg;

	localparam int VALUE_BITS   = 16;
	localparam int FRAC_BITS    = 12;
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 3;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_USER_COUNT     = 3'd0,
		REG_ITEM_COUNT     = 3'd1,
		REG_FACTOR_COUNT   = 3'd2,
		REG_LEARNING_RATE  = 3'd3,
		REG_REGULARIZATION = 3'd4,
		REG_GLOBAL_MEAN    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TRAIN = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TSEL_USER_FACTOR = 2'd0,
		TSEL_ITEM_FACTOR = 2'd1,
		TSEL_USER_BIAS   = 2'd2,
		TSEL_ITEM_BIAS   = 2'd3
	} tsel_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic decode;
		logic wr_entry;
		logic rd_capture;
		logic acc_clear;
		logic bias_rd;
		logic dot_issue;
		logic err_pred;
		logic err_final;
		logic upd_issue;
		logic upd_bias;
		logic k_clear;
		logic k_inc;
		logic finish;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic in_range;
		logic nf_zero;
		logic k_last;
		logic busy;
		logic upd_write;
	} dp_stat_t;

	// saturate to the signed value range
	function automatic value_t sat_value(input logic signed [47:0] x);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sd32767;
		lo = -48'sd32768;
		if (x > hi) return value_t'(hi);
		else if (x < lo) return value_t'(lo);
		else return value_t'(x);
	endfunction

endpackage

>>> rtl/lfsu_if.sv
// Request and response channel interfaces.
interface lfsu_req_if;
	import lfsu_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [1:0]          table_select;
	logic [11:0]         user_index;
	logic [11:0]         item_index;
	logic [4:0]          factor_index;
	logic signed [15:0]  write_value;
	logic signed [15:0]  rating_value;

	modport source(output valid, operation, table_select, user_index, item_index,
		factor_index, write_value, rating_value, input ready);
	modport sink(input valid, operation, table_select, user_index, item_index,
		factor_index, write_value, rating_value, output ready);
endinterface

interface lfsu_rsp_if;
	import lfsu_pkg::*;
	logic                valid;
	logic                ready;
	logic signed [15:0]  prediction_error;
	logic signed [15:0]  read_value;
	logic                status;

	modport source(output valid, prediction_error, read_value, status, input ready);
	modport sink(input valid, prediction_error, read_value, status, output ready);
endinterface

>>> rtl/lfsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfsu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lfsu_ctrl.sv
// Sequencing state machine for train, write and read requests.
module lfsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  lfsu_pkg::dp_stat_t stat,
	output lfsu_pkg::dp_cmd_t  cmd
);
	import lfsu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_WR, S_RD, S_RDCAP, S_BIAS, S_DOT, S_DOTDRAIN,
		S_ERR1, S_ERR2, S_UPD, S_UPDBIAS, S_UPDDRAIN, S_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.capture = req_valid;
			S_DEC: begin
				cmd.decode  = 1'b1;
				cmd.k_clear = 1'b1;
			end
			S_WR:       cmd.wr_entry = 1'b1;
			S_RD:       ;
			S_RDCAP:    cmd.rd_capture = 1'b1;
			S_BIAS: begin
				cmd.acc_clear = 1'b1;
				cmd.bias_rd   = 1'b1;
			end
			S_DOT: begin
				cmd.dot_issue = 1'b1;
				cmd.k_inc     = 1'b1;
			end
			S_DOTDRAIN: ;
			S_ERR1:     cmd.err_pred = 1'b1;
			S_ERR2: begin
				cmd.err_final = 1'b1;
				cmd.k_clear   = 1'b1;
			end
			S_UPD: begin
				cmd.upd_issue = 1'b1;
				cmd.k_inc     = 1'b1;
			end
			S_UPDBIAS: begin
				cmd.upd_issue = 1'b1;
				cmd.upd_bias  = 1'b1;
			end
			S_UPDDRAIN: ;
			S_DONE:     cmd.finish = !rsp_valid_q || rsp_ready;
			default:    ;
		endcase
	end

	// advance state and hold the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:     if (req_valid) state_q <= S_DEC;
				S_DEC: begin
					if (!stat.in_range || stat.op == OP_NONE) begin
						state_q <= S_DONE;
					end else begin
						unique case (stat.op)
							OP_TRAIN: state_q <= S_BIAS;
							OP_WRITE: state_q <= S_WR;
							OP_READ:  state_q <= S_RD;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_WR:       state_q <= S_DONE;
				S_RD:       state_q <= S_RDCAP;
				S_RDCAP:    state_q <= S_DONE;
				S_BIAS:     state_q <= stat.nf_zero ? S_DOTDRAIN : S_DOT;
				S_DOT:      if (stat.k_last) state_q <= S_DOTDRAIN;
				S_DOTDRAIN: if (!stat.busy) state_q <= S_ERR1;
				S_ERR1:     state_q <= S_ERR2;
				S_ERR2:     state_q <= stat.nf_zero ? S_UPDBIAS : S_UPD;
				S_UPD:      if (stat.k_last) state_q <= S_UPDBIAS;
				S_UPDBIAS:  state_q <= S_UPDDRAIN;
				S_UPDDRAIN: if (!stat.busy) state_q <= S_DONE;
				S_DONE:     if (cmd.finish) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/lfsu_datapath.sv
// Tables, configuration registers, dot-product and update pipelines.
module lfsu_datapath #(
	parameter int MAX_USERS   = 4096,
	parameter int MAX_ITEMS   = 4096,
	parameter int MAX_FACTORS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lfsu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lfsu_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic [1:0]                           operation,
	input  logic [1:0]                           table_select,
	input  logic [11:0]                          user_index,
	input  logic [11:0]                          item_index,
	input  logic [4:0]                           factor_index,
	input  logic signed [15:0]                   write_value,
	input  logic signed [15:0]                   rating_value,
	input  lfsu_pkg::dp_cmd_t                    cmd,
	output lfsu_pkg::dp_stat_t                   stat,
	output logic signed [15:0]                   prediction_error,
	output logic signed [15:0]                   read_value,
	output logic                                 status
);
	import lfsu_pkg::*;

	localparam int UFD  = MAX_USERS * MAX_FACTORS;
	localparam int IFD  = MAX_ITEMS * MAX_FACTORS;
	localparam int UFAW = (UFD > 1) ? $clog2(UFD) : 1;
	localparam int IFAW = (IFD > 1) ? $clog2(IFD) : 1;
	localparam int UBAW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam int IBAW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int KW   = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
	localparam int CNTW = 21;

	// configuration registers
	logic [12:0]  user_count_q;
	logic [12:0]  item_count_q;
	logic [5:0]   factor_count_q;
	logic [15:0]  eta_q;
	logic [15:0]  lambda_q;
	value_t       gmean_q;

	// captured request
	op_t          op_q;
	tsel_t        tsel_q;
	logic [11:0]  u_q;
	logic [11:0]  i_q;
	logic [4:0]   f_q;
	value_t       wval_q;
	value_t       rating_q;

	logic              ok_q;
	logic [UFAW-1:0]   ubase_q;
	logic [IFAW-1:0]   ibase_q;
	logic [KW-1:0]     k_q;

	logic [CNTW-1:0]   nu;
	logic [CNTW-1:0]   ni;
	logic [8:0]        nf;
	logic              u_ok;
	logic              i_ok;
	logic              f_ok;
	logic              in_range;
	logic [8:0]        col;

	// RAM ports
	logic              uf_we, if_we, ub_we, ib_we;
	logic [UFAW-1:0]   uf_waddr, uf_raddr;
	logic [IFAW-1:0]   if_waddr, if_raddr;
	logic [UBAW-1:0]   ub_addr;
	logic [IBAW-1:0]   ib_addr;
	value_t            uf_wdata, if_wdata, ub_wdata, ib_wdata;
	value_t            uf_rdata, if_rdata, ub_rdata, ib_rdata;

	// dot-product pipeline
	logic                 dv_s1, dv_s2, bv_s1;
	logic signed [31:0]   prod_s2;
	logic signed [39:0]   acc_q;
	value_t               bu_q, bi_q;
	logic signed [41:0]   pred_q;
	logic signed [41:0]   base_sum;
	logic signed [41:0]   diff;
	logic signed [41:0]   diff_sh;
	value_t               err_q;
	value_t               rd_q;

	// update pipeline, user lane (u) and item lane (i)
	logic                 uv_s1, uv_s2, uv_s3, uv_s4;
	logic                 bias_s1, bias_s2, bias_s3, bias_s4;
	logic [KW-1:0]        k_s1, k_s2, k_s3, k_s4;
	value_t               a_u, o_u, a_i, o_i;
	logic signed [31:0]   eo_u_s2, eo_i_s2;
	logic signed [32:0]   la_u_s2, la_i_s2;
	value_t               a_u_s2, a_i_s2, a_u_s3, a_i_s3, a_u_s4, a_i_s4;
	logic signed [37:0]   inner_u_s3, inner_i_s3;
	logic signed [55:0]   step_u_s4, step_i_s4;
	logic signed [55:0]   d_u, d_i;
	value_t               new_u, new_i;

	value_t               err_out_q, read_out_q;
	logic                 status_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_count_q   <= 13'd4096;
			item_count_q   <= 13'd4096;
			factor_count_q <= 6'd32;
			eta_q          <= 16'd655;
			lambda_q       <= 16'd1311;
			gmean_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_USER_COUNT:     user_count_q   <= cfg_data[12:0];
				REG_ITEM_COUNT:     item_count_q   <= cfg_data[12:0];
				REG_FACTOR_COUNT:   factor_count_q <= cfg_data[5:0];
				REG_LEARNING_RATE:  eta_q          <= cfg_data;
				REG_REGULARIZATION: lambda_q       <= cfg_data;
				REG_GLOBAL_MEAN:    gmean_q        <= value_t'(cfg_data);
				default:            ;
			endcase
		end
	end

	// range checks against the clamped counts
	always_comb begin
		nu = (CNTW'(user_count_q) > CNTW'(MAX_USERS)) ? CNTW'(MAX_USERS)
			: CNTW'(user_count_q);
		ni = (CNTW'(item_count_q) > CNTW'(MAX_ITEMS)) ? CNTW'(MAX_ITEMS)
			: CNTW'(item_count_q);
		nf = (9'(factor_count_q) > 9'(MAX_FACTORS)) ? 9'(MAX_FACTORS) : 9'(factor_count_q);
		u_ok = CNTW'(u_q) < nu;
		i_ok = CNTW'(i_q) < ni;
		f_ok = 9'(f_q) < nf;
		unique case (tsel_q)
			TSEL_USER_FACTOR: in_range = u_ok && f_ok;
			TSEL_ITEM_FACTOR: in_range = i_ok && f_ok;
			TSEL_USER_BIAS:   in_range = u_ok;
			TSEL_ITEM_BIAS:   in_range = i_ok;
			default:          in_range = 1'b0;
		endcase
		if (op_q == OP_TRAIN) begin
			in_range = u_ok && i_ok;
		end
	end

	// capture request, decode bases, step the column counter
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(operation);
			tsel_q   <= tsel_t'(table_select);
			u_q      <= user_index;
			i_q      <= item_index;
			f_q      <= factor_index;
			wval_q   <= write_value;
			rating_q <= rating_value;
		end
		if (cmd.decode) begin
			ok_q    <= in_range;
			ubase_q <= UFAW'(32'(u_q) * 32'(MAX_FACTORS));
			ibase_q <= IFAW'(32'(i_q) * 32'(MAX_FACTORS));
		end
		if (cmd.k_clear) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + KW'(1);
		end
	end

	// table addresses
	assign col      = (op_q == OP_TRAIN) ? 9'(k_q) : 9'(f_q);
	assign uf_raddr = UFAW'(32'(ubase_q) + 32'(col));
	assign if_raddr = IFAW'(32'(ibase_q) + 32'(col));
	assign ub_addr  = UBAW'(u_q);
	assign ib_addr  = IBAW'(i_q);

	// entry writes and update write-back share each write port
	always_comb begin
		uf_we    = (cmd.wr_entry && tsel_q == TSEL_USER_FACTOR) || (uv_s4 && !bias_s4);
		if_we    = (cmd.wr_entry && tsel_q == TSEL_ITEM_FACTOR) || (uv_s4 && !bias_s4);
		ub_we    = (cmd.wr_entry && tsel_q == TSEL_USER_BIAS) || (uv_s4 && bias_s4);
		ib_we    = (cmd.wr_entry && tsel_q == TSEL_ITEM_BIAS) || (uv_s4 && bias_s4);
		uf_waddr = UFAW'(32'(ubase_q) + 32'(cmd.wr_entry ? 9'(f_q) : 9'(k_s4)));
		if_waddr = IFAW'(32'(ibase_q) + 32'(cmd.wr_entry ? 9'(f_q) : 9'(k_s4)));
		uf_wdata = cmd.wr_entry ? wval_q : new_u;
		if_wdata = cmd.wr_entry ? wval_q : new_i;
		ub_wdata = cmd.wr_entry ? wval_q : new_u;
		ib_wdata = cmd.wr_entry ? wval_q : new_i;
	end

	lfsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(UFD)) u_user_factors (
		.clk(clk), .we(uf_we), .waddr(uf_waddr), .wdata(uf_wdata),
		.raddr(uf_raddr), .rdata(uf_rdata)
	);

	lfsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(IFD)) u_item_factors (
		.clk(clk), .we(if_we), .waddr(if_waddr), .wdata(if_wdata),
		.raddr(if_raddr), .rdata(if_rdata)
	);

	lfsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_USERS)) u_user_biases (
		.clk(clk), .we(ub_we), .waddr(ub_addr), .wdata(ub_wdata),
		.raddr(ub_addr), .rdata(ub_rdata)
	);

	lfsu_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_item_biases (
		.clk(clk), .we(ib_we), .waddr(ib_addr), .wdata(ib_wdata),
		.raddr(ib_addr), .rdata(ib_rdata)
	);

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
			dv_s2 <= 1'b0;
			bv_s1 <= 1'b0;
			uv_s1 <= 1'b0;
			uv_s2 <= 1'b0;
			uv_s3 <= 1'b0;
			uv_s4 <= 1'b0;
		end else begin
			dv_s1 <= cmd.dot_issue;
			dv_s2 <= dv_s1;
			bv_s1 <= cmd.bias_rd;
			uv_s1 <= cmd.upd_issue;
			uv_s2 <= uv_s1;
			uv_s3 <= uv_s2;
			uv_s4 <= uv_s3;
		end
	end

	// prediction: biases, dot product, then rounded saturated error
	assign base_sum = 42'(gmean_q) + 42'(bu_q) + 42'(bi_q);
	assign diff     = (42'(rating_q) <<< FRAC_BITS) - pred_q + 42'sd2048;
	assign diff_sh  = diff >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		prod_s2 <= uf_rdata * if_rdata;
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (dv_s2) begin
			acc_q <= acc_q + 40'(prod_s2);
		end
		if (bv_s1) begin
			bu_q <= ub_rdata;
			bi_q <= ib_rdata;
		end
		if (cmd.err_pred) begin
			pred_q <= (base_sum <<< FRAC_BITS) + 42'(acc_q);
		end
		if (cmd.err_final) begin
			err_q <= sat_value(48'(diff_sh));
		end
		if (cmd.rd_capture) begin
			unique case (tsel_q)
				TSEL_USER_FACTOR: rd_q <= uf_rdata;
				TSEL_ITEM_FACTOR: rd_q <= if_rdata;
				TSEL_USER_BIAS:   rd_q <= ub_rdata;
				TSEL_ITEM_BIAS:   rd_q <= ib_rdata;
				default:          rd_q <= '0;
			endcase
		end
	end

	// select old values for the update lanes
	always_comb begin
		a_u = bias_s1 ? bu_q : uf_rdata;
		o_u = bias_s1 ? '0 : if_rdata;
		a_i = bias_s1 ? bi_q : if_rdata;
		o_i = bias_s1 ? '0 : uf_rdata;
	end

	// update stages: products, gradient term, step product
	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		bias_s1 <= cmd.upd_bias;

		eo_u_s2 <= err_q * o_u;
		eo_i_s2 <= err_q * o_i;
		la_u_s2 <= $signed({1'b0, lambda_q}) * a_u;
		la_i_s2 <= $signed({1'b0, lambda_q}) * a_i;
		a_u_s2  <= a_u;
		a_i_s2  <= a_i;
		k_s2    <= k_s1;
		bias_s2 <= bias_s1;

		inner_u_s3 <= bias_s2 ? (38'(err_q) <<< 16) - 38'(la_u_s2)
			: (38'(eo_u_s2) <<< 4) - 38'(la_u_s2);
		inner_i_s3 <= bias_s2 ? (38'(err_q) <<< 16) - 38'(la_i_s2)
			: (38'(eo_i_s2) <<< 4) - 38'(la_i_s2);
		a_u_s3  <= a_u_s2;
		a_i_s3  <= a_i_s2;
		k_s3    <= k_s2;
		bias_s3 <= bias_s2;

		step_u_s4 <= $signed({1'b0, eta_q}) * inner_u_s3;
		step_i_s4 <= $signed({1'b0, eta_q}) * inner_i_s3;
		a_u_s4    <= a_u_s3;
		a_i_s4    <= a_i_s3;
		k_s4      <= k_s3;
		bias_s4   <= bias_s3;
	end

	// round the step, add to the old value, saturate
	always_comb begin
		d_u   = (step_u_s4 + 56'sh80000000) >>> 32;
		d_i   = (step_i_s4 + 56'sh80000000) >>> 32;
		new_u = sat_value(48'(a_u_s4) + 48'(d_u));
		new_i = sat_value(48'(a_i_s4) + 48'(d_i));
	end

	// response payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			err_out_q  <= (op_q == OP_TRAIN && ok_q) ? err_q : '0;
			read_out_q <= (op_q == OP_READ && ok_q) ? rd_q : '0;
			status_q   <= (op_q != OP_NONE) && !ok_q;
		end
	end

	assign prediction_error = err_out_q;
	assign read_value       = read_out_q;
	assign status           = status_q;

	always_comb begin
		stat.op        = op_q;
		stat.in_range  = in_range;
		stat.nf_zero   = (nf == 9'd0);
		stat.k_last    = (9'(k_q) == nf - 9'd1);
		stat.busy      = dv_s1 | dv_s2 | bv_s1 | uv_s1 | uv_s2 | uv_s3 | uv_s4;
		stat.upd_write = uv_s4;
	end

endmodule

>>> rtl/latent_factor_sgd_update.sv
// Top level of the biased matrix-factorization SGD update block.
//
// Requests arrive on req (valid/ready); one response per request leaves on rsp.
// A train request (rating) reads the user and item factor rows and biases,
// forms the prediction error, updates both rows and both biases and returns
// the saturated error. Write and read requests load or unload one table entry.
// Out-of-range indices return status 1 and change nothing.
// A train walks the F factors in use one per cycle through the dot product,
// drains that pipeline, forms the prediction and then the error, walks the
// factors again through the update pipeline, updates the biases and drains;
// with F zero both factor walks are skipped.
// One request is in work at a time; the next is taken once the response is in
// the output register, even while that response still waits on rsp.ready.
// A stalled receiver holds the response; the block stalls in its final state
// only if a second response is ready before the first is taken. Reset clears
// control state and loads configuration defaults; tables hold whatever was
// last written and must be loaded before training. Configuration is written
// through cfg_we/cfg_index/cfg_data, by the user while idle (unenforced).
module latent_factor_sgd_update #(
	parameter int MAX_USERS   = 4096,
	parameter int MAX_ITEMS   = 4096,
	parameter int MAX_FACTORS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfsu_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [lfsu_pkg::CFG_BITS-1:0]     cfg_data,
	lfsu_req_if.sink                          req,
	lfsu_rsp_if.source                        rsp
);
	import lfsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lfsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfsu_datapath #(
		.MAX_USERS   (MAX_USERS),
		.MAX_ITEMS   (MAX_ITEMS),
		.MAX_FACTORS (MAX_FACTORS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (req.operation),
		.table_select     (req.table_select),
		.user_index       (req.user_index),
		.item_index       (req.item_index),
		.factor_index     (req.factor_index),
		.write_value      (req.write_value),
		.rating_value     (req.rating_value),
		.cmd              (cmd),
		.stat             (stat),
		.prediction_error (rsp.prediction_error),
		.read_value       (rsp.read_value),
		.status           (rsp.status)
	);

	// one request in work at a time
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

	// entry writes never collide with update write-back
	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_entry |-> !stat.upd_write)
		else $error("entry write collides with update write-back");

	// response only after the pipelines have drained
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.busy)
		else $error("response issued with pipeline still busy");

endmodule
